FILE: src/bttr_pkg.sv
// shared types, constants and helpers of the background tile pixel renderer
`timescale 1ns / 1ps
package bttr_pkg;

  // video memory geometry
  localparam int VRAM_BYTES   = 8192;
  localparam int VRAM_AW      = $clog2(VRAM_BYTES);
  localparam int SCREEN_WIDTH = 160;

  // signed tile data sits at 0x8800, as an offset from 0x8000
  localparam logic [VRAM_AW-1:0] TILE_SIGNED_BASE = VRAM_AW'(13'h0800);
  // tile maps at 0x9800 and 0x9C00 share the top two offset bits
  localparam logic [1:0] MAP_REGION = 2'b11;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // result buffer in the back part
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_PALETTE  = 3'd5;

  // lcd control bit positions
  localparam int LCDC_BG_MAP    = 3;
  localparam int LCDC_TILE_DATA = 4;
  localparam int LCDC_WIN_EN    = 5;
  localparam int LCDC_WIN_MAP   = 6;

  // input item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef enum logic {
    JOB_WRITE,
    JOB_RENDER
  } job_kind_e;

  typedef struct packed {
    logic       mode;
    logic [12:0] vram_offset;
    logic [7:0] vram_byte;
    logic [7:0] line_number;
    logic [7:0] column;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_rgba;
    logic [1:0]  shade;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
    logic [7:0] bg_palette;
  } cfg_t;

  // one queue entry: a memory write or a classified pixel fetch
  typedef struct packed {
    job_kind_e          kind;
    logic [VRAM_AW-1:0] addr;    // write offset or tile map address
    logic [7:0]         wdata;
    logic [2:0]         row;     // pixel row inside the tile
    logic [2:0]         xbit;    // pixel column inside the tile
    logic               unsig;   // unsigned tile data base
  } job_t;

  // shade to packed rgba
  function automatic logic [31:0] shade_rgba(input logic [1:0] shade);
    logic [7:0] level;
    unique case (shade)
      2'd0: level = 8'hFF;
      2'd1: level = 8'hCC;
      2'd2: level = 8'h77;
      default: level = 8'h00;
    endcase
    return {level, level, level, 8'hFF};
  endfunction

endpackage

FILE: src/background_tile_pixel_renderer.sv
// top level of the background tile pixel renderer
// Input channel (in_valid_i, in_stall_o, in_data_i) takes one transaction per
// cycle: mode 0 stores vram_byte at vram_offset in the 8 KiB video memory,
// mode 1 renders the pixel at line_number and column. Each on-screen render
// gives one result on the output channel (out_valid_o, out_stall_i,
// out_data_o) in order; writes and off-screen renders give none.
// A render passes in order through the queue, the map read, the tile pattern
// read and the result buffer. Throughput: one transaction per cycle while the
// receiver keeps up, set by the single read port of each of the three memory
// copies (map, low plane, high plane).
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle; indexes above the palette register are ignored.
// Reset clears the configuration registers, the job queue and the result
// buffer; video memory contents stay undefined until written, there is no
// clearing pass. When the receiver stalls, the four-entry result buffer
// absorbs the pixels in flight, the back part stops issuing fetches, and
// once the two-entry queue fills the input channel stalls.
`timescale 1ns / 1ps
module background_tile_pixel_renderer
  import bttr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic queue_full;
  logic push;
  job_t job_in;
  logic job_valid;
  job_t job_head;
  logic pop;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LCD_CONTROL: cfg_d.lcd_control = cfg_data_i;
        REG_SCROLL_X:    cfg_d.scroll_x    = cfg_data_i;
        REG_SCROLL_Y:    cfg_d.scroll_y    = cfg_data_i;
        REG_WINDOW_X:    cfg_d.window_x    = cfg_data_i;
        REG_WINDOW_Y:    cfg_d.window_y    = cfg_data_i;
        REG_BG_PALETTE:  cfg_d.bg_palette  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify incoming transactions
  bttr_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .queue_full_i(queue_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // decoupling queue
  bttr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (queue_full),
    .valid_o(job_valid),
    .head_o (job_head),
    .pop_i  (pop)
  );

  // memory and pixel pipeline
  bttr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_i      (job_head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: src/bttr_ram.sv
// generic single write port ram with registered read, read-first
`timescale 1ns / 1ps
module bttr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // a read at the written address returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bttr_queue.sv
// short job queue between the front and back parts
`timescale 1ns / 1ps
module bttr_queue
  import bttr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o,
  input  logic pop_i
);

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, wptr_d;
  logic [QUEUE_AW-1:0] rptr_q, rptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

endmodule

FILE: src/bttr_front.sv
// front part: accepts input transactions and classifies them into jobs
`timescale 1ns / 1ps
module bttr_front
  import bttr_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic       accept;
  logic       on_screen;
  logic       win;
  logic       map_sel;
  logic [7:0] ypos;
  logic [7:0] xpos;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // off-screen pixels are taken and dropped
  assign on_screen = ({1'b0, in_data_i.column} < 9'(SCREEN_WIDTH));

  // window or background selection
  assign win = cfg_i.lcd_control[LCDC_WIN_EN] && (cfg_i.window_y <= in_data_i.line_number);
  assign map_sel = win ? cfg_i.lcd_control[LCDC_WIN_MAP] : cfg_i.lcd_control[LCDC_BG_MAP];

  // pixel position in map space, wrapping at 8 bits
  always_comb begin
    if (win) begin
      ypos = in_data_i.line_number - cfg_i.window_y;
    end else begin
      ypos = in_data_i.line_number + cfg_i.scroll_y;
    end
    if (win && (in_data_i.column >= cfg_i.window_x)) begin
      xpos = in_data_i.column - cfg_i.window_x;
    end else begin
      xpos = in_data_i.column + cfg_i.scroll_x;
    end
  end

  // job build
  always_comb begin
    job_o.wdata = in_data_i.vram_byte;
    job_o.row   = ypos[2:0];
    job_o.xbit  = xpos[2:0];
    job_o.unsig = cfg_i.lcd_control[LCDC_TILE_DATA];
    if (in_data_i.mode == MODE_WRITE) begin
      job_o.kind = JOB_WRITE;
      job_o.addr = in_data_i.vram_offset;
      push_o     = accept;
    end else begin
      job_o.kind = JOB_RENDER;
      job_o.addr = {MAP_REGION, map_sel, ypos[7:3], xpos[7:3]};
      push_o     = accept && on_screen;
    end
  end

endmodule

FILE: src/bttr_back.sv
// back part: memory writes, map and tile fetch, shading and result buffer
`timescale 1ns / 1ps
module bttr_back
  import bttr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // pipeline stage registers
  logic       map_valid_q;
  logic [2:0] map_row_q;
  logic [2:0] map_xbit_q;
  logic       map_unsig_q;
  logic       pix_valid_q;
  logic [2:0] pix_xbit_q;

  // result buffer
  out_item_t         obuf_q [OUT_DEPTH];
  logic [OUT_AW-1:0] owptr_q, owptr_d;
  logic [OUT_AW-1:0] orptr_q, orptr_d;
  logic [OUT_CW-1:0] ocount_q, ocount_d;

  logic               is_write;
  logic               room;
  logic               map_re;
  logic               vram_we;
  logic [7:0]         tile_num;
  logic [VRAM_AW-1:0] tile_base;
  logic [VRAM_AW-1:0] lo_addr;
  logic [VRAM_AW-1:0] hi_addr;
  logic [7:0]         lo_byte;
  logic [7:0]         hi_byte;
  logic [2:0]         bit_sel;
  logic [1:0]         cnum;
  logic [1:0]         shade;
  out_item_t          result;
  logic               opush;
  logic               opop;

  // issue a fetch only when the buffer can hold every pixel in flight; writes need no room
  assign is_write = (job_i.kind == JOB_WRITE);
  assign room = ({1'b0, ocount_q} + (OUT_CW + 1)'(map_valid_q) + (OUT_CW + 1)'(pix_valid_q))
                < (OUT_CW + 1)'(OUT_DEPTH);
  assign pop_o   = job_valid_i && (is_write || room);
  assign vram_we = pop_o && is_write;
  assign map_re  = pop_o && !is_write;

  // three copies of video memory so each fetch has its own read port
  bttr_ram #(
    .WIDTH(8),
    .DEPTH(VRAM_BYTES)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(job_i.addr),
    .wdata_i(job_i.wdata),
    .re_i   (map_re),
    .raddr_i(job_i.addr),
    .rdata_o(tile_num)
  );

  // tile pattern address from the map entry
  always_comb begin
    if (map_unsig_q) begin
      tile_base = {1'b0, tile_num, 4'b0000};
    end else begin
      tile_base = {1'b0, tile_num ^ 8'h80, 4'b0000} + TILE_SIGNED_BASE;
    end
    lo_addr = tile_base | VRAM_AW'({map_row_q, 1'b0});
    hi_addr = tile_base | VRAM_AW'({map_row_q, 1'b1});
  end

  bttr_ram #(
    .WIDTH(8),
    .DEPTH(VRAM_BYTES)
  ) u_lo_ram (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(job_i.addr),
    .wdata_i(job_i.wdata),
    .re_i   (map_valid_q),
    .raddr_i(lo_addr),
    .rdata_o(lo_byte)
  );

  bttr_ram #(
    .WIDTH(8),
    .DEPTH(VRAM_BYTES)
  ) u_hi_ram (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(job_i.addr),
    .wdata_i(job_i.wdata),
    .re_i   (map_valid_q),
    .raddr_i(hi_addr),
    .rdata_o(hi_byte)
  );

  // colour number, palette and rgba
  assign bit_sel = 3'd7 - pix_xbit_q;
  assign cnum    = {hi_byte[bit_sel], lo_byte[bit_sel]};
  assign shade   = cfg_i.bg_palette[{cnum, 1'b0} +: 2];
  assign result.pixel_rgba = shade_rgba(shade);
  assign result.shade      = shade;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      map_valid_q <= map_re;
      pix_valid_q <= map_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    map_row_q   <= job_i.row;
    map_xbit_q  <= job_i.xbit;
    map_unsig_q <= job_i.unsig;
    pix_xbit_q  <= map_xbit_q;
  end

  // result buffer control
  assign opush       = pix_valid_q;
  assign out_valid_o = (ocount_q != '0);
  assign opop        = out_valid_o && !out_stall_i;
  assign out_data_o  = obuf_q[orptr_q];

  always_comb begin
    owptr_d  = opush ? owptr_q + 1'b1 : owptr_q;
    orptr_d  = opop ? orptr_q + 1'b1 : orptr_q;
    ocount_d = ocount_q;
    if (opush && !opop) begin
      ocount_d = ocount_q + 1'b1;
    end else if (!opush && opop) begin
      ocount_d = ocount_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q  <= '0;
      orptr_q  <= '0;
      ocount_q <= '0;
    end else begin
      owptr_q  <= owptr_d;
      orptr_q  <= orptr_d;
      ocount_q <= ocount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      obuf_q[owptr_q] <= result;
    end
  end

endmodule

FILE: tb/background_tile_pixel_renderer_tb.sv
// self-checking testbench of the background tile pixel renderer
`timescale 1ns / 1ps
module background_tile_pixel_renderer_tb;
  import bttr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 16;
  localparam int HOLD_CYCLES    = 120;

  // register indexes past the palette, which the block ignores
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // tile map offsets from the start of video memory
  localparam logic [VRAM_AW-1:0] MAP_LOW_OFF  = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_OFF = 13'h1C00;

  // mirror of video memory, registers and pixels still to come
  class pixel_scoreboard;
    logic [7:0] vram [VRAM_BYTES];
    bit         written [VRAM_BYTES];
    cfg_t       regs;
    out_item_t  expected_pixels [$];
    int         errors;

    function new();
      regs   = '0;
      errors = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
      case (idx)
        REG_LCD_CONTROL: regs.lcd_control = data;
        REG_SCROLL_X:    regs.scroll_x    = data;
        REG_SCROLL_Y:    regs.scroll_y    = data;
        REG_WINDOW_X:    regs.window_x    = data;
        REG_WINDOW_Y:    regs.window_y    = data;
        REG_BG_PALETTE:  regs.bg_palette  = data;
        default: ;
      endcase
    endfunction

    // tile map entry and position inside the tile for a screen pixel
    function void locate(input logic [7:0] line, input logic [7:0] col,
                         output logic [VRAM_AW-1:0] map_a,
                         output logic [2:0] row, output logic [2:0] xbit);
      bit         win;
      bit         high_map;
      logic [7:0] ypos;
      logic [7:0] xpos;
      win = regs.lcd_control[LCDC_WIN_EN] && (regs.window_y <= line);
      high_map = win ? regs.lcd_control[LCDC_WIN_MAP] : regs.lcd_control[LCDC_BG_MAP];
      ypos = win ? line - regs.window_y : regs.scroll_y + line;
      xpos = col + regs.scroll_x;
      if (win && col >= regs.window_x) xpos = col - regs.window_x;
      map_a = (high_map ? MAP_HIGH_OFF : MAP_LOW_OFF) + {3'b000, ypos[7:3], xpos[7:3]};
      row   = ypos[2:0];
      xbit  = xpos[2:0];
    endfunction

    // address of the low bitplane byte of one tile row
    function logic [VRAM_AW-1:0] plane_addr(input logic [7:0] tile, input logic [2:0] row);
      if (regs.lcd_control[LCDC_TILE_DATA]) return {1'b0, tile, row, 1'b0};
      return TILE_SIGNED_BASE + {1'b0, tile ^ 8'h80, row, 1'b0};
    endfunction

    function logic [31:0] shade_to_rgba(input logic [1:0] s);
      logic [7:0] lvl;
      case (s)
        2'd0: lvl = 8'hFF;
        2'd1: lvl = 8'hCC;
        2'd2: lvl = 8'h77;
        default: lvl = 8'h00;
      endcase
      return {lvl, lvl, lvl, 8'hFF};
    endfunction

    function out_item_t predict_pixel(input logic [7:0] line, input logic [7:0] col);
      logic [VRAM_AW-1:0] map_a;
      logic [VRAM_AW-1:0] lo_a;
      logic [2:0]         row;
      logic [2:0]         xbit;
      logic [7:0]         lo;
      logic [7:0]         hi;
      logic [1:0]         cnum;
      out_item_t          res;
      locate(line, col, map_a, row, xbit);
      lo_a = plane_addr(vram[map_a], row);
      lo   = vram[lo_a];
      hi   = vram[lo_a + 13'd1];
      cnum = {hi[3'd7 - xbit], lo[3'd7 - xbit]};
      res.shade      = regs.bg_palette[2 * cnum +: 2];
      res.pixel_rgba = shade_to_rgba(res.shade);
      return res;
    endfunction

    // accepted input transaction: store a byte or queue a pixel
    function void take_input(input in_item_t it);
      if (it.mode == MODE_WRITE) begin
        vram[it.vram_offset]    = it.vram_byte;
        written[it.vram_offset] = 1'b1;
      end else if (it.column < SCREEN_WIDTH) begin
        expected_pixels.push_back(predict_pixel(it.line_number, it.column));
      end
    endfunction

    // accepted output transaction against the oldest pending pixel
    function void check_pixel(input out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h/%0d",
                 $time, got.pixel_rgba, got.shade);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_rgba !== want.pixel_rgba) begin
        $display("%0t: pixel_rgba mismatch, expected %h actual %h",
                 $time, want.pixel_rgba, got.pixel_rgba);
        errors++;
      end
      if (got.shade !== want.shade) begin
        $display("%0t: shade mismatch, expected %0d actual %0d",
                 $time, want.shade, got.shade);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [7:0]           cfg_data_i  = '0;

  pixel_scoreboard sb = new();
  bit no_idle     = 1'b0;
  int hold_req    = 0;
  int hold_left   = 0;
  int quiet_count = 0;
  int items_sent  = 0;

  background_tile_pixel_renderer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // receiver: random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_req - 1;
      hold_req  = 0;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 7);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pixel(out_data_o);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_count = 0;
    end else begin
      quiet_count = quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_write(input logic [12:0] off, input logic [7:0] data);
    in_item_t it;
    it.mode        = MODE_WRITE;
    it.vram_offset = off;
    it.vram_byte   = data;
    it.line_number = 8'($urandom);
    it.column      = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_render(input logic [7:0] line, input logic [7:0] col);
    in_item_t it;
    it.mode        = MODE_RENDER;
    it.vram_offset = 13'($urandom);
    it.vram_byte   = 8'($urandom);
    it.line_number = line;
    it.column      = col;
    return it;
  endfunction

  // offer one input transaction, called and returning at a falling edge
  task automatic send_item(input in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_input(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // write the given map entry or fill any unwritten byte the pixel needs, then render it
  task automatic render_at(input logic [7:0] line, input logic [7:0] col, input int map_val);
    logic [VRAM_AW-1:0] map_a;
    logic [VRAM_AW-1:0] lo_a;
    logic [2:0]         row;
    logic [2:0]         xbit;
    if (col < SCREEN_WIDTH) begin
      sb.locate(line, col, map_a, row, xbit);
      if (map_val >= 0) send_item(make_write(map_a, map_val[7:0]));
      else if (!sb.written[map_a]) send_item(make_write(map_a, 8'($urandom)));
      lo_a = sb.plane_addr(sb.vram[map_a], row);
      if (!sb.written[lo_a]) send_item(make_write(lo_a, 8'($urandom)));
      if (!sb.written[lo_a + 13'd1]) send_item(make_write(lo_a + 13'd1, 8'($urandom)));
    end
    send_item(make_render(line, col));
  endtask

  // drop valid and wait for every pending pixel
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  // reprogram all registers once the block has gone idle
  task automatic program_regs(input cfg_t c, input bit spare);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(REG_LCD_CONTROL, c.lcd_control);
    write_reg(REG_SCROLL_X, c.scroll_x);
    write_reg(REG_SCROLL_Y, c.scroll_y);
    write_reg(REG_WINDOW_X, c.window_x);
    write_reg(REG_WINDOW_Y, c.window_y);
    write_reg(REG_BG_PALETTE, c.bg_palette);
    if (spare) begin
      write_reg(REG_SPARE_6, 8'($urandom));
      write_reg(REG_SPARE_7, 8'($urandom));
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // random traffic: mostly well-formed pixels, some off-screen and stray writes
  task automatic run_phase(input int budget, input bit mid_pause);
    int         target;
    int         half;
    int         pick;
    bit         paused;
    logic [7:0] line;
    target = items_sent + budget;
    half   = items_sent + budget / 2;
    paused = 1'b0;
    while (items_sent < target) begin
      if (mid_pause && !paused && items_sent >= half) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      line = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(154, 255))
                                         : 8'($urandom_range(0, 153));
      if (pick < 70) render_at(line, 8'($urandom_range(0, SCREEN_WIDTH - 1)), -1);
      else if (pick < 80) send_item(make_render(line, 8'($urandom_range(SCREEN_WIDTH, 255))));
      else send_item(make_write(13'($urandom), 8'($urandom)));
    end
  endtask

  // stimulus
  initial begin
    cfg_t cfg_list [8];
    int   p;
    cfg_list[0] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4};
    cfg_list[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    cfg_list[2] = '{8'h30, 8'($urandom), 8'($urandom), 8'd80, 8'd60, 8'hE4};
    cfg_list[3] = '{8'h68, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 159)),
                    8'($urandom_range(0, 153)), 8'h1B};
    cfg_list[4] = '{8'h18, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom)};
    cfg_list[5] = '{8'h20, 8'd7, 8'd3, 8'h00, 8'h00, 8'h27};
    cfg_list[6] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom)};
    cfg_list[7] = '{8'h50, 8'hFF, 8'hFF, 8'd40, 8'd100, 8'($urandom)};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: window edges, signed tile extremes, off-screen and high lines
    program_regs('{8'h20, 8'h00, 8'h00, 8'd80, 8'd72, 8'hE4}, 1'b1);
    send_item(make_write(13'h0000, 8'h00));
    send_item(make_write(13'h1FFF, 8'hFF));
    render_at(8'd71, 8'd79, 'h80);
    render_at(8'd72, 8'd80, 'h7F);
    render_at(8'd100, 8'd10, 'hFF);
    render_at(8'd153, 8'd159, 'h00);
    render_at(8'd255, 8'd0, -1);
    send_item(make_render(8'd10, 8'd160));
    send_item(make_render(8'd10, 8'd255));

    // random phases over several register settings
    for (p = 0; p < 8; p++) begin
      program_regs(cfg_list[p], p == 6);
      if (p == 3) hold_req = HOLD_CYCLES;
      no_idle = (p == 5);
      run_phase(115, p == 2);
    end
    no_idle = 1'b0;

    // wind down
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0t: %0d mismatches, %0d pixels missing", $time, sb.errors,
               sb.expected_pixels.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: background_tile_pixel_renderer.f
src/bttr_pkg.sv
src/bttr_ram.sv
src/bttr_queue.sv
src/bttr_front.sv
src/bttr_back.sv
src/background_tile_pixel_renderer.sv
tb/background_tile_pixel_renderer_tb.sv
